FILE: rtl/tdfr_pkg.sv
package tdfr_pkg;

  localparam int GRID_WIDTH_DEFAULT  = 16;
  localparam int GRID_HEIGHT_DEFAULT = 16;

  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_BITS  = GLYPH_COLS * GLYPH_ROWS;
  localparam int DIGIT_PITCH = 6;
  localparam int PAIR_WIDTH  = 11;

  localparam logic [6:0] NUMBER_MAX = 7'd99;

  localparam logic [7:0] FADE_STEPS_RESET   = 8'd50;
  localparam logic [7:0] TARGET_RED_RESET   = 8'd0;
  localparam logic [7:0] TARGET_GREEN_RESET = 8'd255;
  localparam logic [7:0] TARGET_BLUE_RESET  = 8'd255;

  typedef enum logic [7:0] {
    REG_FADE_STEPS   = 8'd0,
    REG_TARGET_RED   = 8'd1,
    REG_TARGET_GREEN = 8'd2,
    REG_TARGET_BLUE  = 8'd3
  } reg_index_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [6:0] FONT [0:9][0:4] = '{
    '{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E},
    '{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00},
    '{7'h62, 7'h51, 7'h49, 7'h49, 7'h46},
    '{7'h22, 7'h49, 7'h49, 7'h49, 7'h36},
    '{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10},
    '{7'h2F, 7'h49, 7'h49, 7'h49, 7'h31},
    '{7'h3E, 7'h49, 7'h49, 7'h49, 7'h32},
    '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
    '{7'h36, 7'h49, 7'h49, 7'h49, 7'h36},
    '{7'h26, 7'h49, 7'h49, 7'h49, 7'h3E}
  };

  // Column-major glyph bits: bit col*GLYPH_ROWS+row.
  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [3:0] digit);
    logic [GLYPH_BITS-1:0] g;
    g = '0;
    if (digit <= 4'd9) begin
      for (int c = 0; c < GLYPH_COLS; c++) begin
        g[c*GLYPH_ROWS +: GLYPH_ROWS] = FONT[digit][c];
      end
    end
    return g;
  endfunction

endpackage

FILE: rtl/tdfr_front.sv
module tdfr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic signed [7:0]   shown_number,
  input  logic        [7:0]   step_index,
  input  logic        [7:0]   fade_steps,
  input  logic        [7:0]   target_red,
  input  logic        [7:0]   target_green,
  input  logic        [7:0]   target_blue,
  output logic                cmd_push,
  output tdfr_pkg::cmd_t      cmd_out,
  input  tdfr_pkg::q_status_t cmd_status
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_PUSH} state_t;

  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] low;
    logic [7:0] quo;
  } div_t;

  function automatic div_t div_step(input div_t s, input logic [7:0] d);
    div_t       n;
    logic [8:0] t;
    t = {s.rem, s.low[7]};
    n.low = {s.low[6:0], 1'b0};
    if (t >= {1'b0, d}) begin
      n.rem = 8'(t - {1'b0, d});
      n.quo = {s.quo[6:0], 1'b1};
    end else begin
      n.rem = t[7:0];
      n.quo = {s.quo[6:0], 1'b0};
    end
    return n;
  endfunction

  state_t     state;
  logic [2:0] cnt;
  logic [3:0] tens;
  logic [3:0] ones;
  logic [7:0] step_sat;
  div_t       div_r;
  div_t       div_g;
  div_t       div_b;

  logic [7:0]  fade_eff;
  logic [6:0]  num_clamp;
  logic [14:0] tens_prod;
  logic [3:0]  tens_next;
  logic [6:0]  ones_full;
  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;

  assign fade_eff = (fade_steps == 8'd0) ? 8'd1 : fade_steps;

  always_comb begin
    if (shown_number[7]) begin
      num_clamp = 7'd0;
    end else if (shown_number[6:0] > tdfr_pkg::NUMBER_MAX) begin
      num_clamp = tdfr_pkg::NUMBER_MAX;
    end else begin
      num_clamp = shown_number[6:0];
    end
  end

  // Divide by ten through the reciprocal 205/2048, exact below 180.
  assign tens_prod = num_clamp * 8'd205;
  assign tens_next = tens_prod[14:11];
  assign ones_full = num_clamp - 7'(tens_next) * 7'd10;

  assign prod_r = target_red   * step_sat;
  assign prod_g = target_green * step_sat;
  assign prod_b = target_blue  * step_sat;

  assign full     = (state != S_IDLE);
  assign cmd_push = (state == S_PUSH) && !cmd_status.full;
  assign cmd_out  = '{tens: tens, ones: ones,
                      red: div_r.quo, green: div_g.quo, blue: div_b.quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (push) begin
            tens     <= tens_next;
            ones     <= ones_full[3:0];
            step_sat <= (step_index > fade_eff) ? fade_eff : step_index;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          div_r <= '{rem: prod_r[15:8], low: prod_r[7:0], quo: 8'd0};
          div_g <= '{rem: prod_g[15:8], low: prod_g[7:0], quo: 8'd0};
          div_b <= '{rem: prod_b[15:8], low: prod_b[7:0], quo: 8'd0};
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          div_r <= div_step(div_r, fade_eff);
          div_g <= div_step(div_g, fade_eff);
          div_b <= div_step(div_b, fade_eff);
          cnt   <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!cmd_status.full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/tdfr_cmd_fifo.sv
module tdfr_cmd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tdfr_pkg::cmd_t      din,
  input  logic                pop,
  output tdfr_pkg::cmd_t      dout,
  output tdfr_pkg::q_status_t status
);

  tdfr_pkg::cmd_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign dout         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        mem[wr_ptr] <= din;
        wr_ptr      <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/tdfr_back.sv
module tdfr_back #(
  parameter int GRID_WIDTH  = tdfr_pkg::GRID_WIDTH_DEFAULT,
  parameter int GRID_HEIGHT = tdfr_pkg::GRID_HEIGHT_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  tdfr_pkg::cmd_t      cmd_in,
  input  tdfr_pkg::q_status_t cmd_status,
  output logic                cmd_pop,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          pixel_index,
  output logic [7:0]          red_level,
  output logic [7:0]          green_level,
  output logic [7:0]          blue_level,
  output logic                run_last
);

  localparam int SCAN_BITS = 2 * tdfr_pkg::GLYPH_BITS;
  localparam int X0 = (GRID_WIDTH - tdfr_pkg::PAIR_WIDTH) / 2;
  localparam int Y0 = (GRID_HEIGHT - tdfr_pkg::GLYPH_ROWS) / 2;
  localparam logic [7:0] X0_B    = 8'(X0);
  localparam logic [7:0] FY0_B   = 8'(GRID_HEIGHT - 1 - Y0);
  localparam logic [7:0] W_B     = 8'(GRID_WIDTH);
  localparam logic [7:0] WM1_B   = 8'(GRID_WIDTH - 1);
  localparam logic [7:0] PITCH_B = 8'(tdfr_pkg::DIGIT_PITCH);
  localparam logic [2:0] ROW_LAST = 3'(tdfr_pkg::GLYPH_ROWS - 1);
  localparam logic [2:0] COL_LAST = 3'(tdfr_pkg::GLYPH_COLS - 1);

  logic                 busy;
  logic [SCAN_BITS-1:0] bits;
  logic [2:0]           row;
  logic [2:0]           col;
  logic                 glyph;
  logic [7:0]           red;
  logic [7:0]           green;
  logic [7:0]           blue;
  logic                 out_valid;

  logic        slot_free;
  logic        advance;
  logic        emit;
  logic        scan_done;
  logic [7:0]  x_b;
  logic [7:0]  fy_b;
  logic [15:0] row_base;
  logic [7:0]  index_b;

  assign slot_free = !out_valid || pop;
  assign advance   = busy && (!bits[0] || slot_free);
  assign emit      = busy && bits[0] && slot_free;
  assign scan_done = glyph && (col == COL_LAST) && (row == ROW_LAST);
  assign cmd_pop   = !busy && !cmd_status.empty;
  assign empty     = !out_valid;

  assign x_b      = X0_B + (glyph ? PITCH_B : 8'd0) + {5'd0, col};
  assign fy_b     = FY0_B - {5'd0, row};
  assign row_base = fy_b * W_B;
  assign index_b  = row_base[7:0] + (fy_b[0] ? (WM1_B - x_b) : x_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        busy  <= 1'b1;
        bits  <= {tdfr_pkg::glyph_bits(cmd_in.ones), tdfr_pkg::glyph_bits(cmd_in.tens)};
        row   <= '0;
        col   <= '0;
        glyph <= 1'b0;
        red   <= cmd_in.red;
        green <= cmd_in.green;
        blue  <= cmd_in.blue;
      end
      if (advance) begin
        bits <= {1'b0, bits[SCAN_BITS-1:1]};
        if (row == ROW_LAST) begin
          row <= '0;
          if (col == COL_LAST) begin
            col   <= '0;
            glyph <= 1'b1;
          end else begin
            col <= col + 3'd1;
          end
        end else begin
          row <= row + 3'd1;
        end
        if (scan_done) begin
          busy <= 1'b0;
        end
      end
      if (emit) begin
        out_valid   <= 1'b1;
        pixel_index <= index_b;
        red_level   <= red;
        green_level <= green;
        blue_level  <= blue;
        run_last    <= ~|bits[SCAN_BITS-1:1];
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/two_digit_font_pixel_renderer.sv
// Renders a number clamped to 0..99 as two 5x7 glyphs centred on a serpentine
// LED matrix and delivers one beat per lit pixel (strip index and RGB level),
// with run_last on the final pixel of each frame; the consumer clears the frame
// first. The pixel scanner loads a number and then walks the 70 font bits of both
// glyphs one per cycle, stalling only when pop is held low while a pixel waits.
// The color stage (clamp, digit split, multiply, 8-step divide) takes one number
// at a time, holding full until its command is queued, and runs ahead of the
// scanner through a two-entry command queue. Configuration registers: 0 fade
// steps, 1 target red, 2 target green, 3 target blue; cfg_ready is always high.
module two_digit_font_pixel_renderer #(
  parameter int GRID_WIDTH  = tdfr_pkg::GRID_WIDTH_DEFAULT,
  parameter int GRID_HEIGHT = tdfr_pkg::GRID_HEIGHT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic signed [7:0] shown_number,
  input  logic        [7:0] step_index,
  output logic              empty,
  input  logic              pop,
  output logic        [7:0] pixel_index,
  output logic        [7:0] red_level,
  output logic        [7:0] green_level,
  output logic        [7:0] blue_level,
  output logic              run_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic        [7:0] cfg_index,
  input  logic        [7:0] cfg_data
);

  logic [7:0] fade_steps;
  logic [7:0] target_red;
  logic [7:0] target_green;
  logic [7:0] target_blue;

  logic                cmd_push;
  logic                cmd_pop;
  tdfr_pkg::cmd_t      cmd_wr;
  tdfr_pkg::cmd_t      cmd_rd;
  tdfr_pkg::q_status_t cmd_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_steps   <= tdfr_pkg::FADE_STEPS_RESET;
      target_red   <= tdfr_pkg::TARGET_RED_RESET;
      target_green <= tdfr_pkg::TARGET_GREEN_RESET;
      target_blue  <= tdfr_pkg::TARGET_BLUE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tdfr_pkg::REG_FADE_STEPS:   fade_steps   <= cfg_data;
        tdfr_pkg::REG_TARGET_RED:   target_red   <= cfg_data;
        tdfr_pkg::REG_TARGET_GREEN: target_green <= cfg_data;
        tdfr_pkg::REG_TARGET_BLUE:  target_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  tdfr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .shown_number (shown_number),
    .step_index   (step_index),
    .fade_steps   (fade_steps),
    .target_red   (target_red),
    .target_green (target_green),
    .target_blue  (target_blue),
    .cmd_push     (cmd_push),
    .cmd_out      (cmd_wr),
    .cmd_status   (cmd_status)
  );

  tdfr_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (cmd_push),
    .din    (cmd_wr),
    .pop    (cmd_pop),
    .dout   (cmd_rd),
    .status (cmd_status)
  );

  tdfr_back #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_in      (cmd_rd),
    .cmd_status  (cmd_status),
    .cmd_pop     (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .pixel_index (pixel_index),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level),
    .run_last    (run_last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(cmd_push && cmd_status.full))
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(cmd_pop && cmd_status.empty))
    else $error("command queue read while empty");

  a_push_then_busy: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("color stage took a number without going busy");

endmodule
